// ----- hw/rtl/bbpe_pkg.sv -----
// Package for the bicubic Bezier patch evaluator.
// Shared constants, types and operation codes; no dependencies.
package bbpe_pkg;
	localparam int MAX_SAMPLES_D = 4096;
	localparam int COORD_BITS_D  = 32;
	localparam int FRAC_BITS_D   = 16;
	localparam int CFG_BITS      = 13;
	localparam int GRID_BITS     = 12;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_EVAL = 1'b1
	} func_t;

	typedef enum logic [0:0] {
		REG_SAMPLES_U = 1'b0,
		REG_SAMPLES_V = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_BERN,
		ST_ACC,
		ST_FIN,
		ST_OUT
	} state_t;
endpackage

// ----- hw/rtl/bbpe_ram.sv -----
// Generic single-port write, registered-read RAM.
// No dependencies.
module bbpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/bbpe_lane.sv -----
// One coordinate lane: multiply-accumulate of weights and one coordinate,
// then round and saturate. Uses bbpe_pkg.
module bbpe_lane import bbpe_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_D,
	parameter int WB = 30
) (
	input  logic                         clk,
	input  logic                         clr,
	input  logic                         mac,
	input  logic [WB+1:0]                weight,
	input  logic signed [COORD_BITS-1:0] coord,
	output logic signed [COORD_BITS-1:0] result
);
	localparam int ACC_W = COORD_BITS + WB + 8;
	localparam int RW    = ACC_W - WB;
	localparam int MW    = WB + 3 + COORD_BITS;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] rnd;
	logic signed [RW-1:0]    r;
	logic signed [MW-1:0]    prod;
	localparam logic signed [RW-1:0] CMAX = RW'((64'sd1 <<< (COORD_BITS-1)) - 1);
	localparam logic signed [RW-1:0] CMIN = -CMAX - RW'(1);

	// weight is non-negative; widen both operands to the full product width
	assign prod = MW'($signed({1'b0, weight})) * MW'(coord);

	always_ff @(posedge clk) begin
		if (clr) begin
			acc_q <= '0;
		end else if (mac) begin
			acc_q <= acc_q + ACC_W'(prod);
		end
	end

	// arithmetic shift floors for both signs
	assign rnd = acc_q + (ACC_W'(1) <<< (WB-1));
	assign r   = RW'(rnd >>> WB);

	always_comb begin
		if (r > CMAX) result = CMAX[COORD_BITS-1:0];
		else if (r < CMIN) result = CMIN[COORD_BITS-1:0];
		else result = r[COORD_BITS-1:0];
	end
endmodule

// ----- hw/rtl/bicubic_bezier_patch_eval_unit.sv -----
// Top level of the bicubic Bezier patch evaluator; uses bbpe_pkg, bbpe_ram, bbpe_lane.
//
// A load transfer writes one control point and leaves the block idle. An evaluate
// transfer keeps the block busy once it is accepted: two restoring dividers form
// t and s one quotient bit a cycle, a shared multiplier builds the Bernstein weights
// in fourteen steps, seven per side, then the 16 control points are read from the
// point RAM one per cycle while three coordinate lanes accumulate in parallel,
// state ST_FIN settles rounding and saturation and state ST_OUT loads the output
// register. The next item is taken in the cycle the result appears. An evaluation
// outside the grid goes from the divider state straight to ST_OUT. A result waits
// in the output register while the next item is taken; a second finished evaluation
// holds until the waiting result is transferred.
module bicubic_bezier_patch_eval_unit import bbpe_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_D,
	parameter int COORD_BITS  = COORD_BITS_D
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         func,
	input  logic [3:0]                   point_index,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic signed [COORD_BITS-1:0] coord_z,
	input  logic [GRID_BITS-1:0]         grid_u,
	input  logic [GRID_BITS-1:0]         grid_v,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic signed [COORD_BITS-1:0] out_z,
	output logic                         status,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [0:0]                   cfg_index,
	input  logic [CFG_BITS-1:0]          cfg_data
);
	localparam int WB = ((60 - COORD_BITS) < 30) ? (60 - COORD_BITS) : 30;
	localparam int WW = WB + 2;                 // weight width, up to 3*2^WB
	localparam int SB = $clog2(MAX_SAMPLES+1);
	localparam int NB = GRID_BITS + WB + 1;     // dividend width
	localparam int DB = SB + 1;
	localparam int CNT_B = $clog2(NB + 1);
	localparam int PW = 3 * COORD_BITS;
	localparam int MAXS_I = (MAX_SAMPLES < (1 << CFG_BITS)) ? MAX_SAMPLES :
		(1 << CFG_BITS) - 1;
	localparam logic [CFG_BITS-1:0] MAXS = CFG_BITS'(MAXS_I);
	localparam logic [WW-1:0] ONE = WW'(1) << WB;
	localparam logic [2*WW-1:0] HALF = (2*WW)'(1) << (WB-1);

	state_t state_q, state_d;
	logic [CFG_BITS-1:0] su_q, sv_q;
	logic [CFG_BITS-1:0] su_e, sv_e, nu, nv;
	logic in_xfer, out_xfer, out_load;

	assign cfg_ready = 1'b1;
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	// load the output register once the slot is free or being emptied
	assign out_load = (state_q == ST_OUT) && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			su_q <= CFG_BITS'(9);
			sv_q <= CFG_BITS'(9);
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SAMPLES_U: su_q <= cfg_data;
				REG_SAMPLES_V: sv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		su_e = (su_q < CFG_BITS'(2)) ? CFG_BITS'(2) : ((su_q > MAXS) ? MAXS : su_q);
		sv_e = (sv_q < CFG_BITS'(2)) ? CFG_BITS'(2) : ((sv_q > MAXS) ? MAXS : sv_q);
		nu = su_e - CFG_BITS'(1);
		nv = sv_e - CFG_BITS'(1);
	end

	// control point RAM, x/y/z packed
	logic [3:0] raddr;
	logic [PW-1:0] rdata;
	bbpe_ram #(.WIDTH(PW), .DEPTH(16)) u_ram (
		.clk(clk),
		.we(in_xfer && func_t'(func) == FUNC_LOAD),
		.waddr(point_index),
		.wdata({coord_z, coord_y, coord_x}),
		.raddr(raddr),
		.rdata(rdata)
	);

	// two restoring dividers, one bit per cycle
	logic [NB-1:0] quo_u_q, quo_v_q, num_u_q, num_v_q;
	logic [DB-1:0] rem_u_q, rem_v_q;
	logic [CNT_B-1:0] cnt_q;
	logic [DB-1:0] tru_u, tru_v;
	logic [DB-1:0] du, dv;
	assign du = DB'(nu);
	assign dv = DB'(nv);
	assign tru_u = {rem_u_q[DB-2:0], num_u_q[NB-1]};
	assign tru_v = {rem_v_q[DB-2:0], num_v_q[NB-1]};

	// weights
	logic [WW-1:0] wu_q [4];
	logic [WW-1:0] wv_q [4];
	logic [WW-1:0] t_q, s_q, tt_q, tomt_q, oo_q, w_q;
	logic [3:0] step_q;
	logic [3:0] raddr_q;
	logic [WW-1:0] ma, mb, mres, bern_w;
	logic [2:0] widx;
	logic [2*WW-1:0] prod;
	assign prod = ma * mb;
	assign mres = WW'((prod + HALF) >> WB);
	// B1 and B2 carry the factor three
	assign bern_w = (step_q[2:0] == 3'd4 || step_q[2:0] == 3'd5) ? WW'(3) * mres : mres;
	assign widx = step_q[2:0] - 3'd3;

	// Bernstein schedule over the shared multiplier; u side then v side
	always_comb begin
		logic [WW-1:0] x, omx;
		x   = step_q[3] ? s_q : t_q;
		omx = ONE - x;
		ma = '0;
		mb = '0;
		case (step_q[2:0])
			3'd0: begin ma = x;      mb = x;   end
			3'd1: begin ma = x;      mb = omx; end
			3'd2: begin ma = omx;    mb = omx; end
			3'd3: begin ma = oo_q;   mb = omx; end
			3'd4: begin ma = tomt_q; mb = omx; end
			3'd5: begin ma = tt_q;   mb = omx; end
			3'd6: begin ma = tt_q;   mb = x;   end
			default: ;
		endcase
		if (state_q == ST_ACC) begin
			ma = wu_q[raddr_q[1:0]];
			mb = wv_q[raddr_q[3:2]];
		end
	end

	logic acc_on_s1, acc_clr;
	logic [4:0] acc_cnt_q;
	logic bad_q;
	logic signed [COORD_BITS-1:0] rx, ry, rz;
	assign raddr = raddr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid <= 1'b1;
			else if (out_xfer) out_valid <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_xfer && func_t'(func) == FUNC_EVAL) state_d = ST_DIV;
			end
			ST_DIV:  if (bad_q || cnt_q == CNT_B'(NB)) state_d = bad_q ? ST_OUT : ST_BERN;
			ST_BERN: if (step_q == 4'd14) state_d = ST_ACC;
			ST_ACC:  if (acc_cnt_q == 5'd17) state_d = ST_FIN;
			ST_FIN:  state_d = ST_OUT;
			ST_OUT:  if (!out_valid || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign acc_clr = (state_q == ST_BERN);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				bad_q <= (CFG_BITS'(grid_u) > nu) || (CFG_BITS'(grid_v) > nv);
				num_u_q <= (NB'(grid_u) << WB) + NB'(nu >> 1);
				num_v_q <= (NB'(grid_v) << WB) + NB'(nv >> 1);
				rem_u_q <= '0;
				rem_v_q <= '0;
				cnt_q <= '0;
				step_q <= '0;
				acc_cnt_q <= '0;
				raddr_q <= '0;
			end
			ST_DIV: begin
				// shift in one dividend bit, subtract when it fits
				if (tru_u >= du) begin
					rem_u_q <= tru_u - du;
					quo_u_q <= {quo_u_q[NB-2:0], 1'b1};
				end else begin
					rem_u_q <= tru_u;
					quo_u_q <= {quo_u_q[NB-2:0], 1'b0};
				end
				if (tru_v >= dv) begin
					rem_v_q <= tru_v - dv;
					quo_v_q <= {quo_v_q[NB-2:0], 1'b1};
				end else begin
					rem_v_q <= tru_v;
					quo_v_q <= {quo_v_q[NB-2:0], 1'b0};
				end
				num_u_q <= num_u_q << 1;
				num_v_q <= num_v_q << 1;
				cnt_q <= cnt_q + CNT_B'(1);
				t_q <= WW'(quo_u_q);
				s_q <= WW'(quo_v_q);
			end
			ST_BERN: begin
				// steps 0..6 for u, 8..14 for v; weights land straight from the multiplier
				step_q <= (step_q == 4'd6) ? 4'd8 : step_q + 4'd1;
				case (step_q[2:0])
					3'd0: tt_q <= mres;
					3'd1: tomt_q <= mres;
					3'd2: oo_q <= mres;
					default: ;
				endcase
				if (step_q[2:0] >= 3'd3 && step_q[2:0] <= 3'd6) begin
					if (step_q[3]) wv_q[widx[1:0]] <= bern_w;
					else wu_q[widx[1:0]] <= bern_w;
				end
			end
			ST_ACC: begin
				// weight product and RAM read both align with raddr_q of the last cycle
				acc_cnt_q <= acc_cnt_q + 5'd1;
				if (acc_cnt_q < 5'd16) raddr_q <= raddr_q + 4'd1;
				w_q <= mres;
				acc_on_s1 <= (acc_cnt_q < 5'd16);
			end
			default: ;
		endcase
		if (state_q != ST_ACC) acc_on_s1 <= 1'b0;
		if (out_load) begin
			out_x  <= bad_q ? '0 : rx;
			out_y  <= bad_q ? '0 : ry;
			out_z  <= bad_q ? '0 : rz;
			status <= bad_q;
		end
	end

	// lanes see the registered weight and point of the previous read address
	bbpe_lane #(.COORD_BITS(COORD_BITS), .WB(WB)) u_lane_x (
		.clk(clk), .clr(acc_clr), .mac(acc_on_s1), .weight(w_q),
		.coord(rdata[COORD_BITS-1:0]), .result(rx));
	bbpe_lane #(.COORD_BITS(COORD_BITS), .WB(WB)) u_lane_y (
		.clk(clk), .clr(acc_clr), .mac(acc_on_s1), .weight(w_q),
		.coord(rdata[2*COORD_BITS-1:COORD_BITS]), .result(ry));
	bbpe_lane #(.COORD_BITS(COORD_BITS), .WB(WB)) u_lane_z (
		.clk(clk), .clr(acc_clr), .mac(acc_on_s1), .weight(w_q),
		.coord(rdata[PW-1:2*COORD_BITS]), .result(rz));

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n) in_ready |-> state_q == ST_IDLE)
		else $error("input taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n) out_valid && status |-> out_x == '0)
		else $error("error result carries data");
`endif
endmodule

// ----- sim/bicubic_bezier_patch_eval_unit_test.sv -----
// Testbench for the bicubic Bezier patch evaluator: directed and random loads and evaluations.
// Depends on bbpe_pkg and bicubic_bezier_patch_eval_unit; checks every result
// against a fixed-point surface predictor kept in a small scoreboard class.
module bicubic_bezier_patch_eval_unit_test;
	import bbpe_pkg::*;

	localparam int WB   = 28;                 // weight fraction bits at 32-bit coordinates
	localparam longint unsigned W_ONE  = 64'd1 << WB;
	localparam longint unsigned W_HALF = 64'd1 << (WB - 1);
	localparam longint C_MAX = 64'sd2147483647;
	localparam longint C_MIN = -64'sd2147483648;

	typedef struct {
		logic signed [COORD_BITS_D-1:0] x;
		logic signed [COORD_BITS_D-1:0] y;
		logic signed [COORD_BITS_D-1:0] z;
		logic                           status;
	} surf_point_t;

	// Surface predictor with its own copy of the control net and the sample counts.
	class patch_scoreboard;
		longint      net [16][3];
		int unsigned count_u = 9;
		int unsigned count_v = 9;
		surf_point_t pending_q[$];
		int          errors  = 0;
		int          checked = 0;

		function void set_reg(reg_idx_t idx, logic [CFG_BITS-1:0] val);
			if (idx == REG_SAMPLES_U) count_u = val;
			else count_v = val;
		endfunction

		function longint unsigned wmul(longint unsigned a, longint unsigned b);
			return (a * b + W_HALF) >> WB;
		endfunction

		function int unsigned clamp_count(int unsigned v);
			if (v < 2) return 2;
			if (v > MAX_SAMPLES_D) return MAX_SAMPLES_D;
			return v;
		endfunction

		function void bernstein(longint unsigned idx, longint unsigned n,
				output longint unsigned w[4]);
			longint unsigned t, omt, tt;
			t   = ((idx << WB) + n / 2) / n;
			omt = W_ONE - t;
			tt  = wmul(t, t);
			w[0] = wmul(wmul(omt, omt), omt);
			w[1] = 3 * wmul(wmul(t, omt), omt);
			w[2] = 3 * wmul(tt, omt);
			w[3] = wmul(tt, t);
		endfunction

		function logic signed [COORD_BITS_D-1:0] round_sat(longint acc);
			longint r;
			r = (acc + longint'(W_HALF)) >>> WB;   // arithmetic shift floors
			if (r > C_MAX) r = C_MAX;
			if (r < C_MIN) r = C_MIN;
			return r[COORD_BITS_D-1:0];
		endfunction

		// Note an accepted input transfer; an evaluation queues one surface point.
		function void note_item(func_t f, logic [3:0] pi, logic signed [31:0] cx,
				logic signed [31:0] cy, logic signed [31:0] cz,
				logic [GRID_BITS-1:0] gu, logic [GRID_BITS-1:0] gv);
			longint unsigned nu, nv, w;
			longint unsigned wu[4], wv[4];
			longint acc[3];
			surf_point_t res;
			if (f == FUNC_LOAD) begin
				net[pi][0] = cx;
				net[pi][1] = cy;
				net[pi][2] = cz;
				return;
			end
			nu = clamp_count(count_u) - 1;
			nv = clamp_count(count_v) - 1;
			if (gu > nu || gv > nv) begin
				res = '{x: '0, y: '0, z: '0, status: 1'b1};
				pending_q.push_back(res);
				return;
			end
			bernstein(gu, nu, wu);
			bernstein(gv, nv, wv);
			acc = '{0, 0, 0};
			for (int b = 0; b < 4; b++)
				for (int a = 0; a < 4; a++) begin
					w = wmul(wu[a], wv[b]);
					for (int c = 0; c < 3; c++)
						acc[c] += longint'(w) * net[a + 4 * b][c];
				end
			res.x = round_sat(acc[0]);
			res.y = round_sat(acc[1]);
			res.z = round_sat(acc[2]);
			res.status = 1'b0;
			pending_q.push_back(res);
		endfunction

		// Compare one accepted result against the oldest queued surface point.
		function void check_point(surf_point_t got);
			surf_point_t want;
			if (pending_q.size() == 0) begin
				$error("result with no pending surface point: x=%0d y=%0d z=%0d status=%0d",
					got.x, got.y, got.z, got.status);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			checked++;
			if (got.x !== want.x) begin
				$error("out_x expected %0d actual %0d", want.x, got.x);
				errors++;
			end
			if (got.y !== want.y) begin
				$error("out_y expected %0d actual %0d", want.y, got.y);
				errors++;
			end
			if (got.z !== want.z) begin
				$error("out_z expected %0d actual %0d", want.z, got.z);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status expected %0d actual %0d", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	func_t func = FUNC_LOAD;
	logic [3:0] point_index = '0;
	logic signed [COORD_BITS_D-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
	logic [GRID_BITS-1:0] grid_u = '0, grid_v = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [COORD_BITS_D-1:0] out_x, out_y, out_z;
	logic status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	reg_idx_t cfg_index = REG_SAMPLES_U;
	logic [CFG_BITS-1:0] cfg_data = '0;

	patch_scoreboard sb = new();
	int items_sent = 0;
	int long_hold  = 0;     // cycles the receiver holds off once, set by the main flow

	bicubic_bezier_patch_eval_unit dut (
		.clk, .arst_n, .in_valid, .in_ready, .func, .point_index,
		.coord_x, .coord_y, .coord_z, .grid_u, .grid_v,
		.out_valid, .out_ready, .out_x, .out_y, .out_z, .status,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop well beyond the slowest correct run, with gaps on both sides and the long hold-off.
	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Offer one item after a random gap; hold valid and payload until the transfer.
	task automatic send_item(func_t f, logic [3:0] pi, logic signed [31:0] cx,
			logic signed [31:0] cy, logic signed [31:0] cz,
			logic [GRID_BITS-1:0] gu, logic [GRID_BITS-1:0] gv);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) gap = 0;   // stretches with no idling
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		point_index <= pi;
		coord_x     <= cx;
		coord_y     <= cy;
		coord_z     <= cz;
		grid_u      <= gu;
		grid_v      <= gv;
		do @(posedge clk); while (!in_ready);
		sb.note_item(f, pi, cx, cy, cz, gu, gv);
		items_sent++;
	endtask

	// Drop valid, let every result drain, then allow the block to finish a trailing load.
	task automatic drain_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Write one register; only called with the block idle.
	task automatic write_reg(reg_idx_t idx, logic [CFG_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic logic [GRID_BITS-1:0] pick_index(int unsigned count);
		int unsigned n;
		n = sb.clamp_count(count) - 1;
		if ($urandom_range(0, 9) == 0) return GRID_BITS'($urandom_range(0, 4095));
		if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? GRID_BITS'(n) : '0;
		return GRID_BITS'($urandom_range(0, n));
	endfunction

	// Receiver: random stalls per result, plus one long hold-off on request.
	initial begin
		int stall;
		surf_point_t got;
		wait (arst_n === 1'b1);
		forever begin
			stall = $urandom_range(0, 7);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (long_hold > 0) begin
				stall = long_hold;
				long_hold = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = '{x: out_x, y: out_y, z: out_z, status: status};
			sb.check_point(got);
		end
	end

	initial begin
		logic signed [31:0] corner[16];
		int unsigned setting_u[6];
		int unsigned setting_v[6];
		int unsigned cu, cv;

		setting_u = '{9, 2, 0, 4096, 8191, 5};
		setting_v = '{9, 2, 1, 4096, 3, 8191};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: load the full net with extreme coordinates, then evaluate corners,
		// the center, the far grid index and both out-of-grid directions.
		corner = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh00010000, 32'shffff0000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh55555555, 32'shaaaaaaaa, 32'sh7fffffff,
			32'sh80000000, 32'sh12345678, 32'sh7fffffff, 32'sh80000000};
		for (int k = 0; k < 16; k++)
			send_item(FUNC_LOAD, 4'(k), corner[k], corner[15 - k], ~corner[k], '0, '0);
		send_item(FUNC_EVAL, 0, 0, 0, 0, 0, 0);
		send_item(FUNC_EVAL, 0, 0, 0, 0, 8, 8);
		send_item(FUNC_EVAL, 0, 0, 0, 0, 4, 4);
		send_item(FUNC_EVAL, 0, 0, 0, 0, 9, 0);
		send_item(FUNC_EVAL, 0, 0, 0, 0, 0, 9);
		send_item(FUNC_EVAL, 0, 0, 0, 0, 12'hfff, 12'hfff);
		for (int k = 0; k < 16; k++)    // x and z at the positive limit, y at the negative: saturation edge
			send_item(FUNC_LOAD, 4'(k), 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, '0, '0);
		send_item(FUNC_EVAL, 0, 0, 0, 0, 3, 5);

		// Random phases, one register setting each, extremes included.
		for (int ph = 0; ph < 6; ph++) begin
			drain_block();
			cu = setting_u[ph];
			cv = setting_v[ph];
			write_reg(REG_SAMPLES_U, CFG_BITS'(cu));
			write_reg(REG_SAMPLES_V, CFG_BITS'(cv));
			if (ph == 2) long_hold = 600;   // fill the block while the sender keeps offering
			for (int n = 0; n < 120; n++) begin
				if ($urandom_range(0, 4) == 0)
					send_item(FUNC_LOAD, 4'($urandom_range(0, 15)), $urandom, $urandom,
						$urandom, GRID_BITS'($urandom_range(0, 4095)),
						GRID_BITS'($urandom_range(0, 4095)));
				else
					send_item(FUNC_EVAL, 4'($urandom_range(0, 15)), $urandom, $urandom,
						$urandom, pick_index(cu), pick_index(cv));
			end
		end

		drain_block();
		$display("covered %0d input transfers and %0d checked surface points over six",
			items_sent, sb.checked);
		$display("sample-count settings, including clamped and out-of-grid cases");
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
